[hdl/otr_pkg.sv]
// Shared types and constants for the overlapping tile router.
// Used by otr_axis, otr_emit and overlapping_tile_router; depends on nothing.
package otr_pkg;

  localparam int FIELD_W = 16;
  localparam int PIXEL_W = 32;
  localparam int INDEX_W = 3;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [INDEX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_H_OVERLAP    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_V_OVERLAP    = 3'd5;

  // Tiles along one axis that hold the current position
  typedef struct packed {
    logic               err;   // overlap out of range on this axis
    logic               two;   // a second tile holds the position
    logic [FIELD_W-1:0] idx0;
    logic [FIELD_W-1:0] pos0;
    logic [FIELD_W-1:0] idx1;
    logic [FIELD_W-1:0] pos1;
  } axis_hits_t;

  // Copy sequencer status seen by the top level
  typedef struct packed {
    logic busy;        // an item is held in the job register
    logic take_next;   // the job register frees or is empty this cycle
  } emit_status_t;

endpackage

[hdl/otr_axis.sv]
// One axis of the tile grid: position counters, tile lookup and step logic.
// Depends on otr_pkg.
module otr_axis #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,          // an item is accepted
  input  logic                        clear,       // start counting from zero
  input  logic                        adv,         // step this axis
  input  logic [otr_pkg::FIELD_W-1:0] tile_size,
  input  logic [otr_pkg::FIELD_W-1:0] overlap,
  input  logic [otr_pkg::FIELD_W-1:0] image_size,
  output otr_pkg::axis_hits_t         hits,
  output logic                        wrap
);

  localparam int AW = ((COORD_BITS > otr_pkg::FIELD_W) ? COORD_BITS : otr_pkg::FIELD_W) + 2;

  logic [COORD_BITS-1:0] count, first_tile, offset;
  logic [COORD_BITS-1:0] count_cur, first_cur, offset_cur;
  logic [COORD_BITS-1:0] count_next, first_next, offset_next;

  logic [otr_pkg::FIELD_W-1:0] tile_eff, ov_eff, stride;
  logic                        ov_full, ov_half;
  logic [AW-1:0] cnt_w, first_w, off_w, tile_w, stride_w, img_w, start_w;
  logic [AW-1:0] off_inc_w, off_wrap_w, off_sub_w, first_inc_w;
  logic          has_next;

  // Geometry: zero tile size acts as one, an overlap at or above the tile is dropped
  always_comb begin
    tile_eff = (tile_size == '0) ? otr_pkg::FIELD_W'(1) : tile_size;
    ov_full  = (overlap >= tile_eff);
    ov_half  = ({overlap, 1'b0} > {1'b0, tile_eff});
    ov_eff   = ov_full ? '0 : overlap;
    stride   = tile_eff - ov_eff;
  end

  assign count_cur  = clear ? '0 : count;
  assign first_cur  = clear ? '0 : first_tile;
  assign offset_cur = clear ? '0 : offset;

  always_comb begin
    cnt_w       = {{(AW-COORD_BITS){1'b0}}, count_cur};
    first_w     = {{(AW-COORD_BITS){1'b0}}, first_cur};
    off_w       = {{(AW-COORD_BITS){1'b0}}, offset_cur};
    tile_w      = {{(AW-otr_pkg::FIELD_W){1'b0}}, tile_eff};
    stride_w    = {{(AW-otr_pkg::FIELD_W){1'b0}}, stride};
    img_w       = {{(AW-otr_pkg::FIELD_W){1'b0}}, image_size};
    start_w     = (cnt_w >= off_w) ? (cnt_w - off_w) : '0;
    has_next    = ((start_w + tile_w) < img_w);
    off_inc_w   = off_w + AW'(1);
    off_wrap_w  = off_inc_w - stride_w;
    off_sub_w   = off_w - stride_w;
    first_inc_w = first_w + AW'(1);
  end

  // The successor tile starts one stride later, so the position in it is offset - stride
  always_comb begin
    hits.err  = ov_full | ov_half;
    hits.two  = (off_w >= stride_w) && has_next;
    hits.idx0 = first_w[otr_pkg::FIELD_W-1:0];
    hits.pos0 = off_w[otr_pkg::FIELD_W-1:0];
    hits.idx1 = first_inc_w[otr_pkg::FIELD_W-1:0];
    hits.pos1 = off_sub_w[otr_pkg::FIELD_W-1:0];
  end

  // Step: wrap at the image edge, move to the next tile at the tile edge
  always_comb begin
    wrap = ((cnt_w + AW'(1)) >= img_w);
    if (wrap) begin
      count_next  = '0;
      first_next  = '0;
      offset_next = '0;
    end else if ((off_inc_w >= tile_w) && has_next) begin
      count_next  = count_cur + COORD_BITS'(1);
      first_next  = first_cur + COORD_BITS'(1);
      offset_next = off_wrap_w[COORD_BITS-1:0];
    end else begin
      count_next  = count_cur + COORD_BITS'(1);
      first_next  = first_cur;
      offset_next = off_inc_w[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      first_tile <= '0;
      offset     <= '0;
    end else if (en) begin
      count      <= adv ? count_next  : count_cur;
      first_tile <= adv ? first_next  : first_cur;
      offset     <= adv ? offset_next : offset_cur;
    end
  end

endmodule

[hdl/otr_emit.sv]
// Job register and copy sequencer: sends one tile copy per cycle to the result register while it is free.
// Depends on otr_pkg.
module otr_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [otr_pkg::PIXEL_W-1:0] pixel_in,
  input  logic                        err_in,
  input  otr_pkg::axis_hits_t         col_in,
  input  otr_pkg::axis_hits_t         row_in,
  output otr_pkg::emit_status_t       status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [otr_pkg::FIELD_W-1:0] tile_row,
  output logic [otr_pkg::FIELD_W-1:0] tile_col,
  output logic [otr_pkg::FIELD_W-1:0] row_in_tile,
  output logic [otr_pkg::FIELD_W-1:0] col_in_tile,
  output logic [otr_pkg::PIXEL_W-1:0] pixel_out,
  output logic                        last,
  output logic                        overlap_error
);

  logic                        job_valid;
  logic [otr_pkg::PIXEL_W-1:0] job_pixel;
  logic                        job_err;
  otr_pkg::axis_hits_t         job_col, job_row;
  logic                        row_sel, col_sel;
  logic                        slot_free, take, last_copy;

  assign slot_free = !out_valid || out_ready;
  assign take      = job_valid && slot_free;
  assign last_copy = (row_sel == job_row.two) && (col_sel == job_col.two);

  assign status.busy      = job_valid;
  assign status.take_next = !job_valid || (take && last_copy);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      row_sel   <= 1'b0;
      col_sel   <= 1'b0;
    end else if (load) begin
      job_valid <= 1'b1;
      row_sel   <= 1'b0;
      col_sel   <= 1'b0;
    end else if (take) begin
      if (last_copy) begin
        job_valid <= 1'b0;
      end else if (col_sel != job_col.two) begin
        col_sel <= 1'b1;
      end else begin
        col_sel <= 1'b0;
        row_sel <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_pixel <= pixel_in;
      job_err   <= err_in;
      job_col   <= col_in;
      job_row   <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tile_row      <= row_sel ? job_row.idx1 : job_row.idx0;
      row_in_tile   <= row_sel ? job_row.pos1 : job_row.pos0;
      tile_col      <= col_sel ? job_col.idx1 : job_col.idx0;
      col_in_tile   <= col_sel ? job_col.pos1 : job_col.pos0;
      pixel_out     <= job_pixel;
      last          <= last_copy;
      overlap_error <= job_err;
    end
  end

endmodule

[hdl/overlapping_tile_router.sv]
// Top level of the overlapping tile router: configuration registers, both axes, copy sequencer.
// Depends on otr_pkg, otr_axis and otr_emit.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one raster-order pixel per item;
//   start_of_image on an item clears the position counters before that pixel.
//   Output channel (out_valid/out_ready) gives one item per tile holding the
//   pixel (one, two or four), tile rows outer and tile columns inner, with
//   last set on the final copy of the pixel.
//   Configuration: write cfg_data into register cfg_index while cfg_we is high;
//   write only while the block is idle.
// Path: an accepted pixel is held in the job register, and each of its copies
//   is then registered in the result register that drives the output.
// Throughput: one pixel per cycle when each pixel falls in a single tile and
//   out_ready stays high; a pixel with several copies holds the copy sequencer
//   until its last copy is taken, and the input sees backpressure meanwhile.
// Reset: counters clear to the image origin, registers take 640x480 with a
//   single tile and no overlap, both channels go empty.
// Stall: while out_ready is low the result register holds its item; the job
//   register keeps one more pixel and then in_ready drops.
module overlapping_tile_router #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [otr_pkg::INDEX_W-1:0] cfg_index,
  input  logic [otr_pkg::FIELD_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [otr_pkg::PIXEL_W-1:0] pixel,
  input  logic                        start_of_image,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [otr_pkg::FIELD_W-1:0] tile_row,
  output logic [otr_pkg::FIELD_W-1:0] tile_col,
  output logic [otr_pkg::FIELD_W-1:0] row_in_tile,
  output logic [otr_pkg::FIELD_W-1:0] col_in_tile,
  output logic [otr_pkg::PIXEL_W-1:0] pixel_out,
  output logic                        last,
  output logic                        overlap_error
);

  logic [otr_pkg::FIELD_W-1:0] image_width, image_height;
  logic [otr_pkg::FIELD_W-1:0] tile_width, tile_height;
  logic [otr_pkg::FIELD_W-1:0] h_overlap, v_overlap;

  logic                  accept;
  logic                  col_wrap, row_wrap;
  otr_pkg::axis_hits_t   col_hits, row_hits;
  otr_pkg::emit_status_t emit_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= otr_pkg::FIELD_W'(640);
      image_height <= otr_pkg::FIELD_W'(480);
      tile_width   <= otr_pkg::FIELD_W'(640);
      tile_height  <= otr_pkg::FIELD_W'(480);
      h_overlap    <= '0;
      v_overlap    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        otr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        otr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        otr_pkg::REG_TILE_WIDTH:   tile_width   <= cfg_data;
        otr_pkg::REG_TILE_HEIGHT:  tile_height  <= cfg_data;
        otr_pkg::REG_H_OVERLAP:    h_overlap    <= cfg_data;
        otr_pkg::REG_V_OVERLAP:    v_overlap    <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Take a new pixel whenever the job register is empty or frees up this cycle
  assign in_ready = emit_status.take_next;
  assign accept   = in_valid && in_ready;

  // Columns step on every pixel; rows step only when the column counter wraps
  otr_axis #(.COORD_BITS(COORD_BITS)) u_col_axis (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .clear      (start_of_image),
    .adv        (1'b1),
    .tile_size  (tile_width),
    .overlap    (h_overlap),
    .image_size (image_width),
    .hits       (col_hits),
    .wrap       (col_wrap)
  );

  otr_axis #(.COORD_BITS(COORD_BITS)) u_row_axis (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .clear      (start_of_image),
    .adv        (col_wrap),
    .tile_size  (tile_height),
    .overlap    (v_overlap),
    .image_size (image_height),
    .hits       (row_hits),
    .wrap       (row_wrap)
  );

  otr_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .pixel_in      (pixel),
    .err_in        (col_hits.err | row_hits.err),
    .col_in        (col_hits),
    .row_in        (row_hits),
    .status        (emit_status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tile_row      (tile_row),
    .tile_col      (tile_col),
    .row_in_tile   (row_in_tile),
    .col_in_tile   (col_in_tile),
    .pixel_out     (pixel_out),
    .last          (last),
    .overlap_error (overlap_error)
  );

  // An accepted pixel always lands in the job register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> emit_status.busy)
    else $error("accepted pixel not held in job register");

  // A busy job register behind a stalled result register blocks the input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (emit_status.busy && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while copies are stalled");

  // A copy that is not the last one leaves the pixel in the job register
  a_more_copies: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |-> emit_status.busy)
    else $error("job register empty while copies remain");

  // A pixel accepted on the last row but not in the last column is held or sent
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && row_wrap && !col_wrap) |=> (out_valid || emit_status.busy))
    else $error("row wrap outside column wrap lost an item");

endmodule
